@@ hw/rtl/mkpc_pkg.sv @@
package mkpc_pkg;

    // Port and storage geometry
    localparam int MAX_PINS      = 16;
    localparam int MAX_KEYS      = 16;
    localparam int PIN_COUNT_DEF = 16;
    localparam int PIN_IDX_W     = 4;
    localparam int KEY_ID_W      = 4;
    localparam int HOLD_W        = 16;
    localparam int KIND_W        = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [HOLD_W-1:0] HOLD_MAX     = '1;
    localparam logic [HOLD_W-1:0] LIMIT_RESET  = 16'd50;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_MASK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EV_ENABLE  = 2'd2;

    // Event kinds
    localparam logic [KIND_W-1:0] EV_SHORT        = 2'd0;
    localparam logic [KIND_W-1:0] EV_LONG         = 2'd1;
    localparam logic [KIND_W-1:0] EV_LONGPRESSING = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    // Result of one key update step
    typedef struct packed {
        logic              down;
        logic [HOLD_W-1:0] count;
        logic              ev_valid;
        logic [KIND_W-1:0] kind;
    } t_key_upd;

endpackage

@@ hw/rtl/mkpc_key_unit.sv @@
module mkpc_key_unit (
    input  logic                       i_pressed,
    input  logic                       i_down,
    input  logic [mkpc_pkg::HOLD_W-1:0] i_count,
    input  logic [mkpc_pkg::HOLD_W-1:0] i_limit,
    output mkpc_pkg::t_key_upd         o_upd
);

    logic [mkpc_pkg::HOLD_W-1:0] w_inc;

    // Saturating hold count increment
    assign w_inc = (i_count == mkpc_pkg::HOLD_MAX) ? i_count : i_count + 1'b1;

    // Classify one key against its stored state
    always_comb begin
        o_upd.ev_valid = 1'b0;
        o_upd.kind     = mkpc_pkg::EV_SHORT;
        priority if (i_pressed && !i_down) begin
            o_upd.down  = 1'b1;
            o_upd.count = '0;
        end else if (!i_pressed && i_down) begin
            o_upd.down     = 1'b0;
            o_upd.count    = i_count;
            o_upd.ev_valid = 1'b1;
            o_upd.kind     = (i_count < i_limit) ? mkpc_pkg::EV_SHORT : mkpc_pkg::EV_LONG;
        end else if (i_down) begin
            o_upd.down     = 1'b1;
            o_upd.count    = w_inc;
            o_upd.ev_valid = (w_inc > i_limit);
            o_upd.kind     = mkpc_pkg::EV_LONGPRESSING;
        end else begin
            // Key stays up: hold its state
            o_upd.down  = 1'b0;
            o_upd.count = i_count;
        end
    end

endmodule

@@ hw/rtl/multi_key_press_classifier.sv @@
// Multi-key press classifier.
// Input channel (i_in_valid / o_in_stall / i_pin_levels): one word per scan
// tick with the 16 sampled pin levels, low meaning pressed. Pins set in
// key_mask are keys, numbered densely from the lowest pin up.
// Output channel (o_out_valid / i_out_stall / o_key_id, o_event_kind,
// o_last_event): zero or more event words per tick in ascending key order;
// o_last_event marks the final event of a tick.
// Configuration: write i_cfg_data to register i_cfg_index when i_cfg_we is
// high; 0 key_mask (clears all key state), 1 long_press_ticks, 2 event_enable.
// Sequencing: a sequencer walks the pins through one shared key update unit,
// one pin per cycle while the scan does not wait (see below). The scan state
// takes min(PIN_COUNT,16) pins, the flush state then sends the pending
// event, and the next word is taken back in the idle state. The first event
// of a tick goes through the pending slot and then the output register.
// o_in_stall is high while a tick is being worked on.
// A stalled receiver holds the output register; the scan waits only when a
// second event is found while both the output and the pending slot are full.
// Reset: all keys up, key_mask 0, long_press_ticks 50, events disabled.
module multi_key_press_classifier #(
    parameter int PIN_COUNT = mkpc_pkg::PIN_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [mkpc_pkg::MAX_PINS-1:0]     i_pin_levels,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mkpc_pkg::KEY_ID_W-1:0]     o_key_id,
    output logic [mkpc_pkg::KIND_W-1:0]       o_event_kind,
    output logic                              o_last_event,
    input  logic                              i_cfg_we,
    input  logic [mkpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mkpc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int SCAN_PINS = (PIN_COUNT < mkpc_pkg::MAX_PINS) ? PIN_COUNT
                                                                 : mkpc_pkg::MAX_PINS;
    localparam logic [mkpc_pkg::PIN_IDX_W-1:0] LAST_PIN =
        mkpc_pkg::PIN_IDX_W'(SCAN_PINS - 1);

    mkpc_pkg::t_state r_state, n_state;

    logic [mkpc_pkg::MAX_PINS-1:0]  r_mask;
    logic [mkpc_pkg::HOLD_W-1:0]    r_limit;
    logic                           r_enable;

    logic [mkpc_pkg::MAX_PINS-1:0]  r_levels;
    logic [mkpc_pkg::PIN_IDX_W-1:0] r_pin;
    logic [mkpc_pkg::KEY_ID_W-1:0]  r_id;

    logic [mkpc_pkg::MAX_KEYS-1:0]  r_down;
    logic [mkpc_pkg::HOLD_W-1:0]    r_hold [mkpc_pkg::MAX_KEYS];

    logic                           r_pend_valid;
    logic [mkpc_pkg::KEY_ID_W-1:0]  r_pend_id;
    logic [mkpc_pkg::KIND_W-1:0]    r_pend_kind;

    logic                           r_out_valid;
    logic [mkpc_pkg::KEY_ID_W-1:0]  r_out_id;
    logic [mkpc_pkg::KIND_W-1:0]    r_out_kind;
    logic                           r_out_last;

    mkpc_pkg::t_key_upd             w_upd;
    logic                           w_accept;
    logic                           w_is_key;
    logic                           w_ev;
    logic                           w_out_free;
    logic                           w_advance;
    logic                           w_flush_out;
    logic                           w_load_out;
    logic                           w_last_pin;

    // Shared key update unit, fed with the key under the scan pointer
    mkpc_key_unit u_key_unit (
        .i_pressed (!r_levels[r_pin]),
        .i_down    (r_down[r_id]),
        .i_count   (r_hold[r_id]),
        .i_limit   (r_limit),
        .o_upd     (w_upd)
    );

    // Sequencer control
    always_comb begin
        w_accept    = i_in_valid && (r_state == mkpc_pkg::ST_IDLE);
        w_is_key    = r_mask[r_pin];
        w_ev        = w_is_key && r_enable && w_upd.ev_valid;
        w_out_free  = !r_out_valid || !i_out_stall;
        w_advance   = (r_state == mkpc_pkg::ST_SCAN) &&
                      !(w_ev && r_pend_valid && !w_out_free);
        w_flush_out = (r_state == mkpc_pkg::ST_FLUSH) && r_pend_valid && w_out_free;
        w_load_out  = (w_advance && w_ev && r_pend_valid) || w_flush_out;
        w_last_pin  = (r_pin == LAST_PIN);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mkpc_pkg::ST_IDLE: begin
                if (w_accept) n_state = mkpc_pkg::ST_SCAN;
            end
            mkpc_pkg::ST_SCAN: begin
                if (w_advance && w_last_pin) n_state = mkpc_pkg::ST_FLUSH;
            end
            mkpc_pkg::ST_FLUSH: begin
                if (!r_pend_valid || w_out_free) n_state = mkpc_pkg::ST_IDLE;
            end
            default: n_state = mkpc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mkpc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers and key down flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_limit  <= mkpc_pkg::LIMIT_RESET;
            r_enable <= 1'b0;
            r_down   <= '0;
        end else begin
            if (w_advance && w_is_key) begin
                r_down[r_id] <= w_upd.down;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mkpc_pkg::REG_KEY_MASK: begin
                        r_mask <= i_cfg_data;
                        r_down <= '0;
                    end
                    mkpc_pkg::REG_LONG_TICKS: r_limit  <= i_cfg_data;
                    mkpc_pkg::REG_EV_ENABLE:  r_enable <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Hold counts: only read while the key is down, and cleared on going down
    always_ff @(posedge i_clk) begin
        if (w_advance && w_is_key) begin
            r_hold[r_id] <= w_upd.count;
        end
    end

    // Scan pointers and captured word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin <= '0;
            r_id  <= '0;
        end else if (w_accept) begin
            r_pin <= '0;
            r_id  <= '0;
        end else if (w_advance) begin
            r_pin <= r_pin + 1'b1;
            if (w_is_key) r_id <= r_id + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_levels <= i_pin_levels;
    end

    // Pending slot: hold the latest event until the next one or the flush
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (w_advance && w_ev) begin
            r_pend_valid <= 1'b1;
        end else if (w_flush_out) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_ev) begin
            r_pend_id   <= r_id;
            r_pend_kind <= w_upd.kind;
        end
    end

    // Output register: drop on take, load from the pending slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (w_out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_id   <= r_pend_id;
            r_out_kind <= r_pend_kind;
            r_out_last <= w_flush_out;
        end
    end

    assign o_in_stall   = (r_state != mkpc_pkg::ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_key_id     = r_out_id;
    assign o_event_kind = r_out_kind;
    assign o_last_event = r_out_last;

    // Checks
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mkpc_pkg::ST_IDLE) |-> !r_pend_valid)
        else $error("pending event left over in idle");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == mkpc_pkg::ST_SCAN))
        else $error("accepted word did not start a scan");

    a_pend_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mkpc_pkg::ST_SCAN && r_pend_valid) |-> (r_pend_id < r_id))
        else $error("pending key id not below scan key id");

    a_id_le_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mkpc_pkg::ST_SCAN) |-> (r_id <= r_pin))
        else $error("key id ahead of pin pointer");

endmodule
